>>> hw/rtl/bfsa_pkg.sv
package bfsa_pkg;

    localparam int SIZE_W    = 17;
    localparam int START_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_BUILD,
        S_COMMIT,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic build_init;
        logic build_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic is_free;
        logic zero_len;
        logic found;
        logic scan_done;
        logic build_done;
    } t_stat;

endpackage

>>> hw/rtl/bfsa_ctrl.sv
module bfsa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_free,
    input  bfsa_pkg::t_stat   i_stat,
    output bfsa_pkg::t_cmd    o_cmd,
    output logic              o_in_ready,
    output logic              o_res_load
);

    bfsa_pkg::t_state r_state;
    bfsa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfsa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bfsa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = bfsa_pkg::S_DECODE;
                end
            end
            bfsa_pkg::S_DECODE: begin
                if (!i_stat.is_free) begin
                    n_state = bfsa_pkg::S_SCAN;
                end else if (i_stat.zero_len) begin
                    n_state = bfsa_pkg::S_RESP;
                end else begin
                    n_state = bfsa_pkg::S_BUILD;
                end
            end
            bfsa_pkg::S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = i_stat.found ? bfsa_pkg::S_BUILD : bfsa_pkg::S_RESP;
                end
            end
            bfsa_pkg::S_BUILD: begin
                if (i_stat.build_done) begin
                    n_state = bfsa_pkg::S_COMMIT;
                end
            end
            bfsa_pkg::S_COMMIT: begin
                n_state = bfsa_pkg::S_RESP;
            end
            bfsa_pkg::S_RESP: begin
                if (i_out_free) begin
                    n_state = bfsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bfsa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready       = (r_state == bfsa_pkg::S_IDLE);
        o_cmd.load       = (r_state == bfsa_pkg::S_IDLE) && i_in_valid;
        o_cmd.scan_step  = (r_state == bfsa_pkg::S_SCAN) && !i_stat.scan_done;
        o_cmd.build_init = (r_state == bfsa_pkg::S_SCAN) && i_stat.scan_done;
        o_cmd.build_step = (r_state == bfsa_pkg::S_BUILD) && !i_stat.build_done;
        o_cmd.commit     = (r_state == bfsa_pkg::S_COMMIT);
        o_res_load       = (r_state == bfsa_pkg::S_RESP) && i_out_free;
    end

endmodule

>>> hw/rtl/bfsa_dp.sv
module bfsa_dp #(
    parameter int MAX_SEGMENTS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bfsa_pkg::t_cmd                     i_cmd,
    input  logic                               i_cfg_we,
    input  logic [bfsa_pkg::SIZE_W-1:0]        i_cfg_wdata,
    input  logic                               i_op,
    input  logic [bfsa_pkg::SIZE_W-1:0]        i_size,
    input  logic [bfsa_pkg::START_W-1:0]       i_start,
    output bfsa_pkg::t_stat                    o_stat,
    output logic [bfsa_pkg::START_W-1:0]       o_grant,
    output logic [bfsa_pkg::STATUS_W-1:0]      o_status
);

    localparam int N    = MAX_SEGMENTS;
    localparam int A    = bfsa_pkg::START_W;
    localparam int LW   = A + 1;
    localparam int CW   = (LW > bfsa_pkg::SIZE_W) ? LW : bfsa_pkg::SIZE_W;
    localparam int IW   = $clog2(N);
    localparam int CNTW = $clog2(N + 1);
    localparam int SUMW = A + 2;

    localparam logic [LW-1:0]   FULL    = {1'b1, {A{1'b0}}};
    localparam logic [CW-1:0]   FULL_CW = CW'(FULL);
    localparam logic [CW-1:0]   RST_TOT = CW'(65536);
    localparam logic [LW-1:0]   RST_LEN = (RST_TOT > FULL_CW) ? FULL : LW'(RST_TOT);
    localparam logic [CNTW-1:0] N_CNT   = CNTW'(N);

    logic [A-1:0]    r_st  [N];
    logic [LW-1:0]   r_ln  [N];
    logic [CNTW-1:0] r_cnt;
    logic [A-1:0]    r_wst [N];
    logic [LW-1:0]   r_wln [N];
    logic [CNTW-1:0] r_wcnt;
    logic [CNTW-1:0] r_wpush;
    logic            r_ovf;
    logic [CNTW-1:0] r_rot;
    logic            r_op;
    logic [bfsa_pkg::SIZE_W-1:0] r_size;
    logic [A-1:0]    r_addr;
    logic [LW-1:0]   r_flen;
    logic            r_found;
    logic [IW-1:0]   r_best;
    logic [LW-1:0]   r_bestlen;
    logic [A-1:0]    r_bestst;
    logic            r_placed;
    logic            r_pv;
    logic [A-1:0]    r_pst;
    logic [LW-1:0]   r_pln;

    logic            hvalid;
    logic            rot_done;
    logic            is_free;
    logic [CW-1:0]   size_cw;
    logic [CW-1:0]   hln_cw;
    logic [LW-1:0]   size_lw;
    logic            fits;
    logic            better;
    logic            is_best;
    logic            cand_v;
    logic [A-1:0]    cand_st;
    logic [LW-1:0]   cand_ln;
    logic            advance;
    logic            set_placed;
    logic            touch;
    logic [SUMW-1:0] merged;
    logic [LW-1:0]   merged_sat;
    logic            flush;
    logic            push;
    logic            pad;
    logic [A-1:0]    push_st;
    logic [LW-1:0]   push_ln;
    logic            gen_done;
    logic [CW-1:0]   cfg_cw;
    logic [CW-1:0]   in_size_cw;

    assign hvalid     = r_rot < r_cnt;
    assign rot_done   = (r_rot == N_CNT);
    assign is_free    = (r_op == bfsa_pkg::OP_FREE);
    assign size_cw    = CW'(r_size);
    assign hln_cw     = CW'(r_ln[0]);
    assign size_lw    = LW'(r_size);
    assign fits       = hvalid && (hln_cw >= size_cw);
    assign better     = !r_found || (r_ln[0] < r_bestlen);
    assign is_best    = r_found && (r_rot == CNTW'(r_best));
    assign gen_done   = rot_done && (!is_free || r_placed);
    assign cfg_cw     = CW'(i_cfg_wdata);
    assign in_size_cw = CW'(i_size);

    always_comb begin
        cand_v     = 1'b0;
        cand_st    = '0;
        cand_ln    = '0;
        advance    = 1'b0;
        set_placed = 1'b0;
        if (!rot_done) begin
            if (is_free && !r_placed && (!hvalid || r_st[0] >= r_addr)) begin
                cand_v     = 1'b1;
                cand_st    = r_addr;
                cand_ln    = r_flen;
                set_placed = 1'b1;
                advance    = !hvalid;
            end else begin
                advance = 1'b1;
                if (hvalid) begin
                    if (!is_free && is_best) begin
                        if (hln_cw > size_cw) begin
                            cand_v  = 1'b1;
                            cand_st = A'(LW'(r_st[0]) + size_lw);
                            cand_ln = r_ln[0] - size_lw;
                        end
                    end else begin
                        cand_v  = 1'b1;
                        cand_st = r_st[0];
                        cand_ln = r_ln[0];
                    end
                end
            end
        end else if (is_free && !r_placed) begin
            cand_v     = 1'b1;
            cand_st    = r_addr;
            cand_ln    = r_flen;
            set_placed = 1'b1;
        end
    end

    always_comb begin
        touch      = r_pv && is_free &&
                     ((SUMW'(r_pst) + SUMW'(r_pln)) == SUMW'(cand_st));
        merged     = SUMW'(r_pln) + SUMW'(cand_ln);
        merged_sat = (merged > SUMW'(FULL)) ? FULL : LW'(merged);
        flush      = 1'b0;
        push       = 1'b0;
        pad        = 1'b0;
        push_st    = r_pst;
        push_ln    = r_pln;
        if (cand_v) begin
            push = r_pv && !touch;
        end else if (gen_done) begin
            if (r_pv) begin
                flush = 1'b1;
                push  = 1'b1;
            end else if (r_wpush != N_CNT && !r_ovf) begin
                push    = 1'b1;
                pad     = 1'b1;
                push_st = '0;
                push_ln = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k < N; k++) begin
                r_st[k] <= '0;
                r_ln[k] <= '0;
            end
            r_st[0]  <= '0;
            r_ln[0]  <= RST_LEN;
            r_cnt    <= CNTW'(1);
            r_rot    <= '0;
            r_found  <= 1'b0;
            r_placed <= 1'b0;
            r_pv     <= 1'b0;
            r_wcnt   <= '0;
            r_wpush  <= '0;
            r_ovf    <= 1'b0;
            r_op     <= bfsa_pkg::OP_ALLOC;
            r_flen   <= '0;
        end else if (i_cfg_we) begin
            for (int k = 1; k < N; k++) begin
                r_st[k] <= '0;
                r_ln[k] <= '0;
            end
            r_st[0] <= '0;
            if (cfg_cw == '0) begin
                r_cnt   <= '0;
                r_ln[0] <= '0;
            end else begin
                r_cnt   <= CNTW'(1);
                r_ln[0] <= (cfg_cw > FULL_CW) ? FULL : LW'(cfg_cw);
            end
        end else begin
            if (i_cmd.load) begin
                r_op     <= i_op;
                r_flen   <= (in_size_cw > FULL_CW) ? FULL : LW'(in_size_cw);
                r_rot    <= '0;
                r_found  <= 1'b0;
                r_placed <= 1'b0;
                r_pv     <= 1'b0;
                r_wcnt   <= '0;
                r_wpush  <= '0;
                r_ovf    <= 1'b0;
            end
            if (i_cmd.build_init) begin
                r_rot <= '0;
            end
            if (i_cmd.scan_step || (i_cmd.build_step && advance)) begin
                for (int k = 0; k < N - 1; k++) begin
                    r_st[k] <= r_st[k+1];
                    r_ln[k] <= r_ln[k+1];
                end
                r_st[N-1] <= r_st[0];
                r_ln[N-1] <= r_ln[0];
                r_rot     <= r_rot + CNTW'(1);
            end
            if (i_cmd.scan_step && fits && better) begin
                r_found <= 1'b1;
            end
            if (i_cmd.build_step) begin
                if (set_placed) begin
                    r_placed <= 1'b1;
                end
                if (cand_v && !touch) begin
                    r_pv <= 1'b1;
                end else if (flush) begin
                    r_pv <= 1'b0;
                end
                if (push) begin
                    if (r_wpush == N_CNT) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_wpush <= r_wpush + CNTW'(1);
                        if (!pad) begin
                            r_wcnt <= r_wcnt + CNTW'(1);
                        end
                    end
                end
            end
            if (i_cmd.commit && !r_ovf) begin
                for (int k = 0; k < N; k++) begin
                    r_st[k] <= r_wst[k];
                    r_ln[k] <= r_wln[k];
                end
                r_cnt <= r_wcnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_size <= i_size;
            r_addr <= A'(i_start);
        end
        if (i_cmd.scan_step && fits && better) begin
            r_best    <= IW'(r_rot);
            r_bestlen <= r_ln[0];
            r_bestst  <= r_st[0];
        end
        if (i_cmd.build_step) begin
            if (cand_v) begin
                if (touch) begin
                    r_pln <= merged_sat;
                end else begin
                    r_pst <= cand_st;
                    r_pln <= cand_ln;
                end
            end
            if (push && r_wpush != N_CNT) begin
                for (int k = 0; k < N - 1; k++) begin
                    r_wst[k] <= r_wst[k+1];
                    r_wln[k] <= r_wln[k+1];
                end
                r_wst[N-1] <= push_st;
                r_wln[N-1] <= push_ln;
            end
        end
    end

    always_comb begin
        o_stat.is_free    = is_free;
        o_stat.zero_len   = (r_flen == '0);
        o_stat.found      = r_found;
        o_stat.scan_done  = rot_done;
        o_stat.build_done = gen_done && !r_pv && ((r_wpush == N_CNT) || r_ovf);
        if (!is_free) begin
            o_status = r_found ? bfsa_pkg::ST_OK : bfsa_pkg::ST_NOFIT;
            o_grant  = r_found ? bfsa_pkg::START_W'(r_bestst) : '0;
        end else begin
            o_status = (r_flen != '0 && r_ovf) ? bfsa_pkg::ST_FULL : bfsa_pkg::ST_OK;
            o_grant  = '0;
        end
    end

    a_wcnt_le_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcnt <= r_wpush)
        else $error("real item count exceeds push count");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= N_CNT)
        else $error("segment count out of range");

    a_commit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !r_ovf && !i_cfg_we) |=> (r_cnt == $past(r_wcnt)))
        else $error("commit did not take the rebuilt count");

endmodule

>>> hw/rtl/best_fit_segment_allocator_core.sv
// Processing: an allocate makes one scan pass and one rebuild pass over the rotating segment
// table, a failed allocate only the scan pass; a free makes one rebuild pass, a zero-length
// free neither pass; a stalled output holds the result back until the output register is free.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset (synchronous, active low): one free segment covering all memory, no result pending.
module best_fit_segment_allocator_core #(
    parameter int MAX_SEGMENTS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bfsa_pkg::SIZE_W-1:0]          i_cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // request_size [16:0], free_start [32:17], zero fill above
    input  logic [bfsa_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // opcode [0]
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // granted_start [15:0]
    output logic [bfsa_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // status [1:0]
    output logic [bfsa_pkg::STATUS_W-1:0]        m_axis_tuser
);

    bfsa_pkg::t_cmd  cmd;
    bfsa_pkg::t_stat stat;
    logic            out_free;
    logic            res_load;
    logic [bfsa_pkg::START_W-1:0]  grant;
    logic [bfsa_pkg::STATUS_W-1:0] status;

    logic                                r_m_valid;
    logic [bfsa_pkg::M_TDATA_W-1:0]      r_m_data;
    logic [bfsa_pkg::STATUS_W-1:0]       r_m_user;

    assign out_free = !r_m_valid || m_axis_tready;

    bfsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (s_axis_tready),
        .o_res_load (res_load)
    );

    bfsa_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (s_axis_tuser),
        .i_size      (s_axis_tdata[16:0]),
        .i_start     (s_axis_tdata[32:17]),
        .o_stat      (stat),
        .o_grant     (grant),
        .o_status    (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_m_data <= grant;
            r_m_user <= status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule
